/* sv/etcd_pkg.sv */
// ----------------------------------------------------------------------------
// etcd_pkg: shared constants, types and tables
// Constants, stage hand-off structs and the month start table used by the
// epoch to calendar date pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package etcd_pkg;

  localparam int EpochW = 32;
  localparam int DaysW  = 16;   // whole days fit below 65536 for any 32-bit epoch
  localparam int YearW  = 12;
  localparam int DoyW   = 9;
  localparam int WdayW  = 3;
  localparam int MonW   = 4;
  localparam int DomW   = 5;

  // seconds / 86400 == (seconds >> 7) / 675
  localparam int DayShift      = 7;
  localparam int DayDiv        = 675;
  localparam int DayXW         = EpochW - DayShift;            // 25
  localparam int DayRecipShift = 34;
  localparam logic [DayXW-1:0] RecipDay =
    DayXW'((64'd1 << DayRecipShift) / DayDiv);
  localparam int DayProdW      = 2 * DayXW;                     // 50
  localparam int DayRemW       = 11;                            // 0..2*675-1

  // four-year cycles counted from 1968-01-01
  localparam int QuadDays       = 1461;
  localparam int QuadRecipShift = 32;
  localparam int QuadRecipW     = 22;
  localparam logic [QuadRecipW-1:0] RecipQuad =
    QuadRecipW'((64'd1 << QuadRecipShift) / QuadDays);
  localparam int QuadProdW      = DaysW + QuadRecipW;          // 38
  localparam int QuadW          = 6;                            // up to 34
  localparam int QuadRemW       = 12;                           // 0..2*1461-1
  localparam int QuadDoyW       = 11;                           // 0..1460

  localparam logic [DaysW-1:0] Offs1968  = DaysW'(731);   // 1968-01-01 .. 1970-01-01
  localparam logic [DaysW-1:0] Mar2100   = DaysW'(47541); // 2100-03-01 in epoch days
  localparam logic [YearW-1:0] QuadBase  = YearW'(1968);
  localparam logic [WdayW-1:0] Sunday7   = WdayW'(7);
  localparam logic [DaysW-1:0] EpochWday = DaysW'(4);     // 1970-01-01 was a Thursday

  typedef struct packed {
    logic [DaysW-1:0] days;
  } day_out_t;

  typedef struct packed {
    logic [YearW-1:0] year;
    logic [DoyW-1:0]  doy;
    logic             leap;
    logic [WdayW-1:0] wday;
  } year_out_t;

  // first day of month m (0 = January) within the year
  function automatic logic [DoyW-1:0] month_start(input logic [MonW-1:0] m,
                                                  input logic leap);
    logic [DoyW-1:0] s;
    case (m)
      4'd0:    s = 9'd0;
      4'd1:    s = 9'd31;
      4'd2:    s = 9'd59;
      4'd3:    s = 9'd90;
      4'd4:    s = 9'd120;
      4'd5:    s = 9'd151;
      4'd6:    s = 9'd181;
      4'd7:    s = 9'd212;
      4'd8:    s = 9'd243;
      4'd9:    s = 9'd273;
      4'd10:   s = 9'd304;
      4'd11:   s = 9'd334;
      default: s = 9'd0;
    endcase
    if (leap && (m >= 4'd2)) begin
      s = s + 9'd1;
    end
    return s;
  endfunction

endpackage

`default_nettype wire

/* sv/etcd_in_if.sv */
// ----------------------------------------------------------------------------
// etcd_in_if: epoch input channel
// Valid/ready channel carrying one epoch seconds value per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface etcd_in_if;
  logic                        valid;
  logic                        ready;
  logic [etcd_pkg::EpochW-1:0] epoch_seconds;

  modport source (output valid, output epoch_seconds, input ready);
  modport sink   (input valid, input epoch_seconds, output ready);
endinterface

`default_nettype wire

/* sv/etcd_out_if.sv */
// ----------------------------------------------------------------------------
// etcd_out_if: calendar date output channel
// Valid/ready channel carrying one calendar date per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface etcd_out_if;
  logic                       valid;
  logic                       ready;
  logic [etcd_pkg::DomW-1:0]  day_of_month;
  logic [etcd_pkg::MonW-1:0]  month_number;
  logic [etcd_pkg::YearW-1:0] year_number;
  logic [etcd_pkg::WdayW-1:0] weekday;

  modport source (output valid, output day_of_month, output month_number,
                  output year_number, output weekday, input ready);
  modport sink   (input valid, input day_of_month, input month_number,
                  input year_number, input weekday, output ready);
endinterface

`default_nettype wire

/* sv/etcd_day_div.sv */
// ----------------------------------------------------------------------------
// etcd_day_div: seconds to whole days
// Three stages: reciprocal multiply, remainder, one-step correction.
// ----------------------------------------------------------------------------
`default_nettype none

module etcd_day_div (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        en,
  input  wire logic                        in_valid,
  input  wire logic [etcd_pkg::EpochW-1:0] secs,
  output logic                             out_valid,
  output etcd_pkg::day_out_t               out_data
);

  // stage 1
  logic                         v1;
  logic [etcd_pkg::DayXW-1:0]   x1;
  logic [etcd_pkg::DayProdW-1:0] prod1;
  // stage 2
  logic                         v2;
  logic [etcd_pkg::DaysW-1:0]   q2;
  logic [etcd_pkg::DayRemW-1:0] r2;

  logic [etcd_pkg::DayXW-1:0]   x_in;
  logic [etcd_pkg::DaysW-1:0]   q_est;
  logic [etcd_pkg::DayXW-1:0]   qm;
  logic [etcd_pkg::DayXW-1:0]   r_full;

  assign x_in   = secs[etcd_pkg::EpochW-1:etcd_pkg::DayShift];
  assign q_est  = prod1[etcd_pkg::DayProdW-1 -: etcd_pkg::DaysW];
  assign qm     = etcd_pkg::DayXW'(q_est) * etcd_pkg::DayXW'(etcd_pkg::DayDiv);
  assign r_full = x1 - qm;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1        <= in_valid;
      v2        <= v1;
      out_valid <= v2;
    end
    if (en) begin
      x1    <= x_in;
      prod1 <= etcd_pkg::DayProdW'(x_in) * etcd_pkg::DayProdW'(etcd_pkg::RecipDay);
      q2    <= q_est;
      r2    <= r_full[etcd_pkg::DayRemW-1:0];
      // estimate is low by at most one
      if (r2 >= etcd_pkg::DayRemW'(etcd_pkg::DayDiv)) begin
        out_data.days <= q2 + etcd_pkg::DaysW'(1);
      end else begin
        out_data.days <= q2;
      end
    end
  end

endmodule

`default_nettype wire

/* sv/etcd_year.sv */
// ----------------------------------------------------------------------------
// etcd_year: days to year, day of year and weekday
// Five stages over four-year cycles from 1968; 2100 is patched as a skipped
// leap day. Weekday by folding octal digits (8 = 1 mod 7).
// ----------------------------------------------------------------------------
`default_nettype none

module etcd_year (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                en,
  input  wire logic                in_valid,
  input  wire etcd_pkg::day_out_t  in_data,
  output logic                     out_valid,
  output etcd_pkg::year_out_t      out_data
);

  // stage 4
  logic                            v4;
  logic [etcd_pkg::DaysW-1:0]      dq4;
  logic [5:0]                      ws4;
  // stage 5
  logic                            v5;
  logic [etcd_pkg::DaysW-1:0]      dq5;
  logic [etcd_pkg::QuadProdW-1:0]  prod5;
  logic [etcd_pkg::WdayW-1:0]      wd5;
  // stage 6
  logic                            v6;
  logic [etcd_pkg::QuadW-1:0]      q6;
  logic [etcd_pkg::QuadRemW-1:0]   r6;
  logic [etcd_pkg::WdayW-1:0]      wd6;
  // stage 7
  logic                            v7;
  logic [etcd_pkg::QuadW-1:0]      q7;
  logic [etcd_pkg::QuadDoyW-1:0]   r7;
  logic [etcd_pkg::WdayW-1:0]      wd7;

  logic [etcd_pkg::DaysW-1:0]      dshift;
  logic [etcd_pkg::DaysW-1:0]      dw;
  logic [5:0]                      wsum;
  logic [3:0]                      wfold;
  logic [etcd_pkg::WdayW-1:0]      wmod;
  logic [etcd_pkg::QuadW-1:0]      q_est;
  logic [etcd_pkg::DaysW:0]        qm;
  logic [etcd_pkg::DaysW:0]        r_full;
  logic [1:0]                      yoff;
  logic [etcd_pkg::QuadDoyW-1:0]   doy_w;

  always_comb begin
    // after Feb 2100 pretend Feb 29 existed so every cycle starts leap
    if (in_data.days >= etcd_pkg::Mar2100) begin
      dshift = in_data.days + etcd_pkg::Offs1968 + etcd_pkg::DaysW'(1);
    end else begin
      dshift = in_data.days + etcd_pkg::Offs1968;
    end
    dw   = in_data.days + etcd_pkg::EpochWday;
    wsum = 6'(dw[2:0]) + 6'(dw[5:3]) + 6'(dw[8:6]) + 6'(dw[11:9])
         + 6'(dw[14:12]) + 6'(dw[15]);
  end

  always_comb begin
    wfold = 4'(ws4[2:0]) + 4'(ws4[5:3]);
    if (wfold >= 4'(etcd_pkg::Sunday7)) begin
      wmod = etcd_pkg::WdayW'(wfold - 4'(etcd_pkg::Sunday7));
    end else begin
      wmod = wfold[etcd_pkg::WdayW-1:0];
    end
  end

  assign q_est  = prod5[etcd_pkg::QuadProdW-1 -: etcd_pkg::QuadW];
  assign qm     = (etcd_pkg::DaysW+1)'(q_est) * (etcd_pkg::DaysW+1)'(etcd_pkg::QuadDays);
  assign r_full = (etcd_pkg::DaysW+1)'(dq5) - qm;

  always_comb begin
    if (r7 < 11'd366) begin
      yoff  = 2'd0;
      doy_w = r7;
    end else if (r7 < 11'd731) begin
      yoff  = 2'd1;
      doy_w = r7 - 11'd366;
    end else if (r7 < 11'd1096) begin
      yoff  = 2'd2;
      doy_w = r7 - 11'd731;
    end else begin
      yoff  = 2'd3;
      doy_w = r7 - 11'd1096;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v4        <= 1'b0;
      v5        <= 1'b0;
      v6        <= 1'b0;
      v7        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v4        <= in_valid;
      v5        <= v4;
      v6        <= v5;
      v7        <= v6;
      out_valid <= v7;
    end
    if (en) begin
      dq4   <= dshift;
      ws4   <= wsum;
      dq5   <= dq4;
      prod5 <= etcd_pkg::QuadProdW'(dq4) * etcd_pkg::QuadProdW'(etcd_pkg::RecipQuad);
      wd5   <= wmod;
      q6    <= q_est;
      r6    <= r_full[etcd_pkg::QuadRemW-1:0];
      wd6   <= wd5;
      if (r6 >= etcd_pkg::QuadRemW'(etcd_pkg::QuadDays)) begin
        q7 <= q6 + etcd_pkg::QuadW'(1);
        r7 <= etcd_pkg::QuadDoyW'(r6 - etcd_pkg::QuadRemW'(etcd_pkg::QuadDays));
      end else begin
        q7 <= q6;
        r7 <= r6[etcd_pkg::QuadDoyW-1:0];
      end
      wd7   <= wd6;
      out_data.year <= etcd_pkg::QuadBase + etcd_pkg::YearW'({q7, 2'b00})
                     + etcd_pkg::YearW'(yoff);
      out_data.doy  <= doy_w[etcd_pkg::DoyW-1:0];
      out_data.leap <= (yoff == 2'd0);
      out_data.wday <= wd7;
    end
  end

endmodule

`default_nettype wire

/* sv/etcd_month.sv */
// ----------------------------------------------------------------------------
// etcd_month: day of year to month and day of month
// Stage one compares against every month start after January in parallel;
// stage two subtracts the chosen start and drives the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module etcd_month (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 en,
  input  wire logic                 in_valid,
  input  wire etcd_pkg::year_out_t  in_data,
  etcd_out_if.source                dst
);

  logic                          v9;
  etcd_pkg::year_out_t           d9;
  logic [etcd_pkg::MonW-1:0]     m9;
  logic [etcd_pkg::MonW-1:0]     m_sel;
  logic [etcd_pkg::DoyW-1:0]     dom_w;

  always_comb begin
    m_sel = '0;
    for (int i = 1; i < 12; i++) begin
      if (in_data.doy >= etcd_pkg::month_start(etcd_pkg::MonW'(i), in_data.leap)) begin
        m_sel = etcd_pkg::MonW'(i);
      end
    end
  end

  assign dom_w = d9.doy - etcd_pkg::month_start(m9, d9.leap) + etcd_pkg::DoyW'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      v9        <= 1'b0;
      dst.valid <= 1'b0;
    end else if (en) begin
      v9        <= in_valid;
      dst.valid <= v9;
    end
    if (en) begin
      d9               <= in_data;
      m9               <= m_sel;
      dst.day_of_month <= dom_w[etcd_pkg::DomW-1:0];
      dst.month_number <= m9 + etcd_pkg::MonW'(1);
      dst.year_number  <= d9.year;
      dst.weekday      <= d9.wday;
    end
  end

endmodule

`default_nettype wire

/* sv/epoch_to_calendar_date.sv */
// ----------------------------------------------------------------------------
// epoch_to_calendar_date: Unix epoch seconds to Gregorian date
// Pipelined conversion of a 32-bit epoch to day, month, year and weekday.
// ----------------------------------------------------------------------------
//
//  channel  modport  payload                                      width
//  -------  -------  -------------------------------------------  ----------
//  epoch    sink     epoch_seconds                                32
//  date     source   day_of_month, month_number, year_number,     5,4,12,3
//                    weekday
//
// One transaction enters per cycle while the pipe is not frozen; the pipeline
// has ten stages (day divider 3, year/weekday 5, month 2).
// Synchronous reset clears every stage valid bit; data registers are not reset.
// All stages share one advance enable: when date holds a result that is not
// taken, the whole pipe freezes and epoch.ready drops, so nothing is lost.
// ----------------------------------------------------------------------------
`default_nettype none

module epoch_to_calendar_date (
  input  wire logic  clk,
  input  wire logic  rst,
  etcd_in_if.sink    epoch,
  etcd_out_if.source date
);

  logic                  en;
  logic                  day_valid;
  etcd_pkg::day_out_t    day_data;
  logic                  year_valid;
  etcd_pkg::year_out_t   year_data;

  // pipe advances whenever the output slot is free or being drained
  assign en          = !date.valid || date.ready;
  assign epoch.ready = en;

  // seconds -> whole days (reciprocal multiply by 1/675 after >>7)
  etcd_day_div u_day_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (epoch.valid),
    .secs      (epoch.epoch_seconds),
    .out_valid (day_valid),
    .out_data  (day_data)
  );

  // days -> year, day of year, leap flag, weekday
  etcd_year u_year (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (day_valid),
    .in_data   (day_data),
    .out_valid (year_valid),
    .out_data  (year_data)
  );

  // day of year -> month, day of month; owns the output register
  etcd_month u_month (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (year_valid),
    .in_data  (year_data),
    .dst      (date)
  );

endmodule

`default_nettype wire
